FILE: src/torus_route_link_load_core_defines.svh
// Assertion macros for the torus route link load RTL.
`ifndef TORUS_ROUTE_LINK_LOAD_CORE_DEFINES_SVH
`define TORUS_ROUTE_LINK_LOAD_CORE_DEFINES_SVH

// Invariant that holds at every clock edge out of reset.
`define TRLL_ASSERT_ALWAYS(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error(msg);

// Same-cycle implication.
`define TRLL_ASSERT_IMPLY(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

FILE: src/trll_pkg.sv
// Types and constants shared by the torus route link load block.
`default_nettype none

package trll_pkg;

    localparam int COORD_W  = 4;
    localparam int LOAD_W   = 5;
    localparam int ROUTE_W  = 5;
    localparam int COUNT_W  = 11;
    localparam int EXCESS_W = 12;

    localparam int DEF_GRID_WIDTH  = 10;
    localparam int DEF_GRID_HEIGHT = 12;
    localparam int DEF_ROUTE_LIMIT = 16;

    localparam logic [LOAD_W-1:0] LOAD_MAX = 5'd31;

    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_REPORT = 2'd1,
        ACT_CLEAR  = 2'd2,
        ACT_NONE   = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_HOP    = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_NOHOP  = 2'd2,
        KIND_REJECT = 2'd3
    } kind_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [COORD_W-1:0] bank_x;
        logic [COORD_W-1:0] bank_y;
        logic [COORD_W-1:0] dest_x;
        logic [COORD_W-1:0] dest_y;
        logic               fabric;
    } route_req_t;

    typedef struct packed {
        logic [1:0]          kind;
        logic                last;
        logic [COORD_W-1:0]  from_x;
        logic [COORD_W-1:0]  from_y;
        logic [COORD_W-1:0]  to_x;
        logic [COORD_W-1:0]  to_y;
        logic [LOAD_W-1:0]   hop_load;
        logic [ROUTE_W-1:0]  route_total;
        logic [COUNT_W-1:0]  links_used;
        logic [LOAD_W-1:0]   peak_load;
        logic [COUNT_W-1:0]  shared_links;
        logic [EXCESS_W-1:0] excess_load;
    } route_res_t;

endpackage

`default_nettype wire

FILE: src/trll_load_ram.sv
// Link load table: single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module trll_load_ram
    import trll_pkg::*;
#(
    parameter int DEPTH = 4 * DEF_GRID_WIDTH * DEF_GRID_HEIGHT,
    parameter int AW    = $clog2(DEPTH)
)(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [AW-1:0]     wr_addr,
    input  wire logic [LOAD_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [AW-1:0]     rd_addr,
    output logic      [LOAD_W-1:0] rd_data
);

    logic [LOAD_W-1:0] mem [DEPTH];
    logic [LOAD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the last read word when no read is issued.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

FILE: src/trll_ctrl.sv
// Route sequencer: RAM clear sweep, hop walk, load read-modify-write, metrics and result register.
`default_nettype none
`include "torus_route_link_load_core_defines.svh"

module trll_ctrl
    import trll_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int ROUTE_LIMIT = DEF_ROUTE_LIMIT,
    parameter int LINK_SLOTS  = 4 * GRID_WIDTH * GRID_HEIGHT,
    parameter int SLOT_AW     = $clog2(LINK_SLOTS)
)(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output logic                    req_stall,
    input  wire route_req_t         req,
    output logic                    res_valid,
    input  wire logic               res_stall,
    output route_res_t              res,
    output logic                    ram_wr_en,
    output logic [SLOT_AW-1:0]      ram_wr_addr,
    output logic [LOAD_W-1:0]       ram_wr_data,
    output logic                    ram_rd_en,
    output logic [SLOT_AW-1:0]      ram_rd_addr,
    input  wire logic [LOAD_W-1:0]  ram_rd_data
);

    typedef enum logic [3:0] {
        ST_CLEAR = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_HOP   = 4'b0100,
        ST_NOTE  = 4'b1000
    } state_t;

    localparam logic [COORD_W-1:0] X_LAST = COORD_W'(GRID_WIDTH - 1);
    localparam logic [COORD_W-1:0] Y_LAST = COORD_W'(GRID_HEIGHT - 1);
    localparam logic [SLOT_AW-1:0] SLOT_LAST = SLOT_AW'(LINK_SLOTS - 1);

    function automatic logic [SLOT_AW-1:0] slot_addr(
        input logic               fab,
        input logic [COORD_W-1:0] x,
        input logic [COORD_W-1:0] y,
        input logic               vert
    );
        logic [15:0] lin;
        lin = ((16'(fab) * 16'(GRID_HEIGHT) + 16'(y)) * 16'(GRID_WIDTH) + 16'(x)) * 16'd2
              + 16'(vert);
        return lin[SLOT_AW-1:0];
    endfunction

    state_t              state_reg, state_next;
    logic [SLOT_AW-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [COORD_W-1:0]  cur_x_reg, cur_x_next;
    logic [COORD_W-1:0]  cur_y_reg, cur_y_next;
    logic [COORD_W-1:0]  dst_x_reg, dst_x_next;
    logic [COORD_W-1:0]  dst_y_reg, dst_y_next;
    logic                fab_reg, fab_next;
    kind_t               note_kind_reg, note_kind_next;
    logic [ROUTE_W-1:0]  route_cnt_reg, route_cnt_next;
    logic [COUNT_W-1:0]  used_cnt_reg, used_cnt_next;
    logic [LOAD_W-1:0]   peak_reg, peak_next;
    logic [COUNT_W-1:0]  shared_cnt_reg, shared_cnt_next;
    logic [EXCESS_W-1:0] excess_cnt_reg, excess_cnt_next;
    logic                res_valid_reg, res_valid_next;
    route_res_t          res_reg, res_next;
    logic                res_load;

    logic                req_fire;
    logic                res_free;
    logic                in_grid;
    logic                step_x;
    logic [COORD_W-1:0]  nx, ny, next_x, next_y;
    logic                hop_last;
    logic                load_sat;
    logic [LOAD_W-1:0]   new_load;
    logic [LOAD_W-1:0]   peak_shown;

    assign req_stall = (state_reg != ST_IDLE);
    assign req_fire  = req_valid && !req_stall;
    assign res_free  = !res_valid_reg || !res_stall;

    assign in_grid = ({1'b0, req.bank_x} < 5'(GRID_WIDTH))  &&
                     ({1'b0, req.dest_x} < 5'(GRID_WIDTH))  &&
                     ({1'b0, req.bank_y} < 5'(GRID_HEIGHT)) &&
                     ({1'b0, req.dest_y} < 5'(GRID_HEIGHT));

    // Hop walk: x first, then y; fabric 0 steps up, fabric 1 steps down, both wrapping.
    always_comb
    begin
        step_x = (cur_x_reg != dst_x_reg);
        if (!fab_reg)
        begin
            nx = (cur_x_reg == X_LAST) ? '0 : cur_x_reg + 1'b1;
            ny = (cur_y_reg == Y_LAST) ? '0 : cur_y_reg + 1'b1;
        end
        else
        begin
            nx = (cur_x_reg == '0) ? X_LAST : cur_x_reg - 1'b1;
            ny = (cur_y_reg == '0) ? Y_LAST : cur_y_reg - 1'b1;
        end
        next_x   = step_x ? nx : cur_x_reg;
        next_y   = step_x ? cur_y_reg : ny;
        hop_last = (next_x == dst_x_reg) && (next_y == dst_y_reg);
        load_sat = (ram_rd_data == LOAD_MAX);
        new_load = load_sat ? ram_rd_data : ram_rd_data + 1'b1;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        cur_x_next      = cur_x_reg;
        cur_y_next      = cur_y_reg;
        dst_x_next      = dst_x_reg;
        dst_y_next      = dst_y_reg;
        fab_next        = fab_reg;
        note_kind_next  = note_kind_reg;
        route_cnt_next  = route_cnt_reg;
        used_cnt_next   = used_cnt_reg;
        peak_next       = peak_reg;
        shared_cnt_next = shared_cnt_reg;
        excess_cnt_next = excess_cnt_reg;
        res_load        = 1'b0;
        res_next        = '0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = slot_addr(fab_reg, cur_x_reg, cur_y_reg, !step_x);
        ram_wr_data     = new_load;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = slot_addr(fab_reg, next_x, next_y, next_x == dst_x_reg);

        case (state_reg)
            ST_CLEAR:
            begin
                ram_wr_en    = 1'b1;
                ram_wr_addr  = clr_cnt_reg;
                ram_wr_data  = '0;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == SLOT_LAST)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire)
                begin
                    cur_x_next = req.bank_x;
                    cur_y_next = req.bank_y;
                    dst_x_next = req.dest_x;
                    dst_y_next = req.dest_y;
                    fab_next   = req.fabric;
                    case (action_t'(req.action))
                        ACT_ADD:
                        begin
                            if (!in_grid || (route_cnt_reg >= ROUTE_W'(ROUTE_LIMIT)))
                            begin
                                note_kind_next = KIND_REJECT;
                                state_next     = ST_NOTE;
                            end
                            else if ((req.bank_x == req.dest_x) &&
                                     (req.bank_y == req.dest_y))
                            begin
                                route_cnt_next = route_cnt_reg + 1'b1;
                                note_kind_next = KIND_NOHOP;
                                state_next     = ST_NOTE;
                            end
                            else
                            begin
                                // Fetch the first link while entering the walk.
                                route_cnt_next = route_cnt_reg + 1'b1;
                                ram_rd_en      = 1'b1;
                                ram_rd_addr    = slot_addr(req.fabric, req.bank_x, req.bank_y,
                                                           req.bank_x == req.dest_x);
                                state_next     = ST_HOP;
                            end
                        end
                        ACT_REPORT:
                        begin
                            note_kind_next = KIND_REPORT;
                            state_next     = ST_NOTE;
                        end
                        ACT_CLEAR:
                        begin
                            route_cnt_next  = '0;
                            used_cnt_next   = '0;
                            peak_next       = '0;
                            shared_cnt_next = '0;
                            excess_cnt_next = '0;
                            clr_cnt_next    = '0;
                            state_next      = ST_CLEAR;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_HOP:
            begin
                if (res_free)
                begin
                    ram_wr_en = 1'b1;
                    if (!load_sat)
                    begin
                        if (ram_rd_data == '0)
                        begin
                            used_cnt_next = used_cnt_reg + 1'b1;
                        end
                        else
                        begin
                            excess_cnt_next = excess_cnt_reg + 1'b1;
                            if (ram_rd_data == LOAD_W'(1))
                            begin
                                shared_cnt_next = shared_cnt_reg + 1'b1;
                            end
                        end
                    end
                    if (new_load > peak_reg)
                    begin
                        peak_next = new_load;
                    end
                    res_load      = 1'b1;
                    res_next.kind = KIND_HOP;
                    res_next.last = hop_last;
                    res_next.from_x   = cur_x_reg;
                    res_next.from_y   = cur_y_reg;
                    res_next.to_x     = next_x;
                    res_next.to_y     = next_y;
                    res_next.hop_load = new_load;
                    cur_x_next = next_x;
                    cur_y_next = next_y;
                    if (hop_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        // Next link differs from the one written back this cycle.
                        ram_rd_en = 1'b1;
                    end
                end
            end
            ST_NOTE:
            begin
                if (res_free)
                begin
                    res_load      = 1'b1;
                    res_next.kind = note_kind_reg;
                    res_next.last = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        peak_shown = ((peak_next == '0) && (route_cnt_next != '0)) ? LOAD_W'(1) : peak_next;
        res_next.route_total  = route_cnt_next;
        res_next.links_used   = used_cnt_next;
        res_next.peak_load    = peak_shown;
        res_next.shared_links = shared_cnt_next;
        res_next.excess_load  = excess_cnt_next;

        if (res_load)
        begin
            res_valid_next = 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_next = 1'b0;
        end
        else
        begin
            res_valid_next = res_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            note_kind_reg  <= KIND_REPORT;
            route_cnt_reg  <= '0;
            used_cnt_reg   <= '0;
            peak_reg       <= '0;
            shared_cnt_reg <= '0;
            excess_cnt_reg <= '0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            note_kind_reg  <= note_kind_next;
            route_cnt_reg  <= route_cnt_next;
            used_cnt_reg   <= used_cnt_next;
            peak_reg       <= peak_next;
            shared_cnt_reg <= shared_cnt_next;
            excess_cnt_reg <= excess_cnt_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_x_reg <= cur_x_next;
        cur_y_reg <= cur_y_next;
        dst_x_reg <= dst_x_next;
        dst_y_reg <= dst_y_next;
        fab_reg   <= fab_next;
        if (res_load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    `TRLL_ASSERT_IMPLY(a_rmw_no_overlap, ram_wr_en && ram_rd_en,
        ram_wr_addr != ram_rd_addr, "read and write-back hit the same link")
    `TRLL_ASSERT_ALWAYS(a_peak_bounded, peak_reg <= route_cnt_reg,
        "peak load exceeds number of routes")
    `TRLL_ASSERT_ALWAYS(a_shared_bounded, shared_cnt_reg <= used_cnt_reg,
        "shared links exceed used links")
    `TRLL_ASSERT_ALWAYS(a_excess_bounded, EXCESS_W'(shared_cnt_reg) <= excess_cnt_reg,
        "excess load below shared link count")

endmodule

`default_nettype wire

FILE: src/torus_route_link_load_core.sv
// Top level of the torus route link load tracker.
`default_nettype none

// Routes packets over a GRID_WIDTH x GRID_HEIGHT torus with two fabrics (fabric 0 walks
// east then south, fabric 1 west then north) and counts the load of every link in a
// table of 4*GRID_WIDTH*GRID_HEIGHT entries held in one synchronous RAM. One transaction
// is taken at a time. Each hop of an add-route transaction is a read-modify-write of its
// link, with the read of the next link issued in the same cycle as the write-back, so the
// RAM's single write port sets the pace; hops wait while a result is held by res_stall.
// Report, rejected and zero-hop routes pass through the note state. After reset and
// after a clear transaction the RAM is swept to zero, one entry per cycle, over all
// 4*GRID_WIDTH*GRID_HEIGHT entries while req_stall stays high. Results sit in an output
// register; while one waits for the consumer, the next is not produced.
module torus_route_link_load_core
    import trll_pkg::*;
#(
    parameter int GRID_WIDTH  = DEF_GRID_WIDTH,
    parameter int GRID_HEIGHT = DEF_GRID_HEIGHT,
    parameter int ROUTE_LIMIT = DEF_ROUTE_LIMIT
)(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    output logic            req_stall,
    input  wire route_req_t req,
    output logic            res_valid,
    input  wire logic       res_stall,
    output route_res_t      res
);

    localparam int LINK_SLOTS = 4 * GRID_WIDTH * GRID_HEIGHT;
    localparam int SLOT_AW    = $clog2(LINK_SLOTS);

    logic               ram_wr_en;
    logic [SLOT_AW-1:0] ram_wr_addr;
    logic [LOAD_W-1:0]  ram_wr_data;
    logic               ram_rd_en;
    logic [SLOT_AW-1:0] ram_rd_addr;
    logic [LOAD_W-1:0]  ram_rd_data;

    trll_ctrl #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ROUTE_LIMIT (ROUTE_LIMIT),
        .LINK_SLOTS  (LINK_SLOTS),
        .SLOT_AW     (SLOT_AW)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .req         (req),
        .res_valid   (res_valid),
        .res_stall   (res_stall),
        .res         (res),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .ram_rd_en   (ram_rd_en),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data)
    );

    trll_load_ram #(
        .DEPTH (LINK_SLOTS),
        .AW    (SLOT_AW)
    ) u_load_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// Self-checking testbench for the torus route link load core: directed, random and stall tests.
`default_nettype none

module tb_top;
    import trll_pkg::*;

    localparam int GW          = DEF_GRID_WIDTH;
    localparam int GH          = DEF_GRID_HEIGHT;
    localparam int RL          = DEF_ROUTE_LIMIT;
    localparam int SLOTS       = 4 * GW * GH;
    localparam int IDLE_PCT    = 29;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 64;
    localparam int CYCLE_LIMIT = 500000;

    logic       clk;
    logic       rst_n;
    logic       req_valid;
    logic       req_stall;
    route_req_t req;
    logic       res_valid;
    logic       res_stall;
    route_res_t res;

    // mirror of the link table and congestion counters
    logic [LOAD_W-1:0]   link_load [SLOTS];
    logic [ROUTE_W-1:0]  routes_taken;
    logic [COUNT_W-1:0]  busy_links;
    logic [LOAD_W-1:0]   top_load;
    logic [COUNT_W-1:0]  hot_links;
    logic [EXCESS_W-1:0] overflow_load;

    route_res_t expected_res[$];

    bit calm;
    bit hold_req;
    int unsigned mismatches;
    int unsigned cycle_count;
    int unsigned sent_count;
    int unsigned results_seen;
    int unsigned hop_count;
    int unsigned reject_count;
    int unsigned clear_count;

    torus_route_link_load_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic void clear_links();
        for (int i = 0; i < SLOTS; i++)
            link_load[i] = '0;
        routes_taken  = '0;
        busy_links    = '0;
        top_load      = '0;
        hot_links     = '0;
        overflow_load = '0;
    endfunction

    function automatic int slot_index(input int fab, input int x, input int y, input int vert);
        return ((fab * GH + y) * GW + x) * 2 + vert;
    endfunction

    function automatic logic [LOAD_W-1:0] bump_link(input int slot);
        logic [LOAD_W-1:0] v;
        v = link_load[slot];
        if (v == LOAD_MAX)
            return v;
        if (v == '0)
            busy_links++;
        else
        begin
            if (v == 1)
                hot_links++;
            overflow_load++;
        end
        v++;
        link_load[slot] = v;
        if (v > top_load)
            top_load = v;
        return v;
    endfunction

    function automatic route_res_t make_res(input kind_t k, input logic fin,
                                            input int fx, input int fy, input int tx,
                                            input int ty, input logic [LOAD_W-1:0] ld);
        route_res_t r;
        r.kind         = k;
        r.last         = fin;
        r.from_x       = COORD_W'(fx);
        r.from_y       = COORD_W'(fy);
        r.to_x         = COORD_W'(tx);
        r.to_y         = COORD_W'(ty);
        r.hop_load     = ld;
        r.route_total  = routes_taken;
        r.links_used   = busy_links;
        // routes without any hop still report a peak of one
        r.peak_load    = (top_load == '0 && routes_taken != '0) ? LOAD_W'(1) : top_load;
        r.shared_links = hot_links;
        r.excess_load  = overflow_load;
        return r;
    endfunction

    function automatic void predict_route(input route_req_t item);
        int sx, sy, dx, dy, fab, hops, walked, cx, cy, nx, ny;
        logic [LOAD_W-1:0] ld;
        sx  = item.bank_x;
        sy  = item.bank_y;
        dx  = item.dest_x;
        dy  = item.dest_y;
        fab = item.fabric;
        if (sx >= GW || dx >= GW || sy >= GH || dy >= GH || routes_taken >= RL)
        begin
            expected_res.push_back(make_res(KIND_REJECT, 1'b1, 0, 0, 0, 0, '0));
            reject_count++;
            return;
        end
        routes_taken++;
        if (fab == 0)
            hops = (dx + GW - sx) % GW + (dy + GH - sy) % GH;
        else
            hops = (sx + GW - dx) % GW + (sy + GH - dy) % GH;
        if (hops == 0)
        begin
            expected_res.push_back(make_res(KIND_NOHOP, 1'b1, 0, 0, 0, 0, '0));
            return;
        end
        cx = sx;
        cy = sy;
        walked = 0;
        while (cx != dx)
        begin
            nx = (fab == 0) ? (cx + 1) % GW : (cx + GW - 1) % GW;
            ld = bump_link(slot_index(fab, cx, cy, 0));
            walked++;
            expected_res.push_back(make_res(KIND_HOP, walked == hops, cx, cy, nx, cy, ld));
            cx = nx;
        end
        while (cy != dy)
        begin
            ny = (fab == 0) ? (cy + 1) % GH : (cy + GH - 1) % GH;
            ld = bump_link(slot_index(fab, cx, cy, 1));
            walked++;
            expected_res.push_back(make_res(KIND_HOP, walked == hops, cx, cy, cx, ny, ld));
            cy = ny;
        end
        hop_count += hops;
    endfunction

    function automatic void predict_item(input route_req_t item);
        case (action_t'(item.action))
            ACT_CLEAR:
            begin
                clear_links();
                clear_count++;
            end
            ACT_REPORT: expected_res.push_back(make_res(KIND_REPORT, 1'b1, 0, 0, 0, 0, '0));
            ACT_ADD:    predict_route(item);
            default:    ;
        endcase
    endfunction

    function automatic route_req_t req_of(input action_t a, input int sx, input int sy,
                                          input int dx, input int dy, input bit fab);
        route_req_t r;
        r.action = a;
        r.bank_x = COORD_W'(sx);
        r.bank_y = COORD_W'(sy);
        r.dest_x = COORD_W'(dx);
        r.dest_y = COORD_W'(dy);
        r.fabric = fab;
        return r;
    endfunction

    function automatic route_req_t random_route();
        int span_x, span_y;
        // keep most routes in a corner so links get shared
        span_x = ($urandom_range(0, 3) == 0) ? GW : 4;
        span_y = ($urandom_range(0, 3) == 0) ? GH : 4;
        return req_of(ACT_ADD, $urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1),
                      $urandom_range(0, span_x - 1), $urandom_range(0, span_y - 1),
                      $urandom_range(0, 1));
    endfunction

    function automatic route_req_t random_item();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 74)
            return random_route();
        else if (roll < 84)
            return req_of(ACT_REPORT, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
        else if (roll < 93)
            return req_of(ACT_ADD, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
        else if (roll < 97)
            return req_of(ACT_NONE, $urandom_range(0, 15), $urandom_range(0, 15),
                          $urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 1));
        else
            return req_of(ACT_CLEAR, 0, 0, 0, 0, 0);
    endfunction

    // Offer one transaction and predict its results once it is taken.
    task automatic send_req(input route_req_t item);
        int idle;
        idle = 0;
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
            idle = $urandom_range(1, 4);
        if (idle > 0)
        begin
            req_valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do @(posedge clk); while (req_stall);
        predict_item(item);
        sent_count++;
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_check
        route_res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            results_seen++;
            if (expected_res.size() == 0)
            begin
                $error("result with no transaction pending: kind %0d", res.kind);
                mismatches++;
            end
            else
            begin
                want = expected_res.pop_front();
                check_field("kind", want.kind, res.kind);
                check_field("last", want.last, res.last);
                check_field("from_x", want.from_x, res.from_x);
                check_field("from_y", want.from_y, res.from_y);
                check_field("to_x", want.to_x, res.to_x);
                check_field("to_y", want.to_y, res.to_y);
                check_field("hop_load", want.hop_load, res.hop_load);
                check_field("route_total", want.route_total, res.route_total);
                check_field("links_used", want.links_used, res.links_used);
                check_field("peak_load", want.peak_load, res.peak_load);
                check_field("shared_links", want.shared_links, res.shared_links);
                check_field("excess_load", want.excess_load, res.excess_load);
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when asked.
    initial
    begin
        int hold_left;
        hold_left = 0;
        res_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_res.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // longest routes on both fabrics, a self route and a report from reset
    task automatic test_extremes();
        send_req(req_of(ACT_REPORT, 15, 15, 15, 15, 1));
        send_req(req_of(ACT_ADD, 0, 0, GW - 1, GH - 1, 0));
        send_req(req_of(ACT_ADD, 0, 0, GW - 1, GH - 1, 1));
        send_req(req_of(ACT_ADD, GW - 1, GH - 1, 0, 0, 1));
        send_req(req_of(ACT_ADD, GW - 1, GH - 1, GW - 1, GH - 1, 0));
    endtask

    task automatic test_rejects();
        send_req(req_of(ACT_ADD, GW, 0, 1, 1, 0));
        send_req(req_of(ACT_ADD, 0, GH, 1, 1, 1));
        send_req(req_of(ACT_ADD, 1, 1, 15, 1, 0));
        send_req(req_of(ACT_ADD, 1, 1, 1, 15, 1));
        send_req(req_of(ACT_NONE, 15, 15, 15, 15, 1));
    endtask

    // pile routes onto the same links until the route limit rejects one
    task automatic test_route_limit();
        while (routes_taken < RL)
            send_req(req_of(ACT_ADD, 4, 4, 6, 5, 0));
        send_req(req_of(ACT_ADD, 4, 4, 6, 5, 0));
        send_req(req_of(ACT_REPORT, 0, 0, 0, 0, 0));
    endtask

    // after a clear, a self route alone lifts the peak to one
    task automatic test_clear();
        send_req(req_of(ACT_CLEAR, 0, 0, 0, 0, 0));
        send_req(req_of(ACT_ADD, 3, 3, 3, 3, 1));
        send_req(req_of(ACT_REPORT, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_traffic(input int count);
        int done, batch;
        route_req_t item;
        done = 0;
        while (done < count)
        begin
            send_req(req_of(ACT_CLEAR, 0, 0, 0, 0, 0));
            done++;
            batch = $urandom_range(6, 20);
            repeat (batch)
            begin
                item = random_item();
                send_req(item);
                if (action_t'(item.action) != ACT_NONE)
                    done++;
            end
        end
    endtask

    task automatic test_calm_stretch(input int count);
        calm = 1'b1;
        test_random_traffic(count);
        calm = 1'b0;
    endtask

    // hold the receiver off while routes keep coming so the input backs up
    task automatic test_backpressure();
        send_req(req_of(ACT_CLEAR, 0, 0, 0, 0, 0));
        // start the hold only once the clear sweep is over
        send_req(random_route());
        hold_req = 1'b1;
        repeat (12)
            send_req(random_route());
    endtask

    initial
    begin
        calm         = 1'b0;
        hold_req     = 1'b0;
        mismatches   = 0;
        cycle_count  = 0;
        sent_count   = 0;
        results_seen = 0;
        hop_count    = 0;
        reject_count = 0;
        clear_count  = 0;
        clear_links();
        rst_n     <= 1'b0;
        req_valid <= 1'b0;
        req       <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_extremes();
        test_rejects();
        test_route_limit();
        test_clear();
        test_backpressure();
        test_calm_stretch(40);
        test_random_traffic(260);

        req_valid <= 1'b0;
        while (expected_res.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("sent %0d transactions (%0d clears), checked %0d results",
                 sent_count, clear_count, results_seen);
        $display("hops %0d, rejected routes %0d, mismatches %0d, cycles %0d",
                 hop_count, reject_count, mismatches, cycle_count);
        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+src
src/trll_pkg.sv
src/trll_load_ram.sv
src/trll_ctrl.sv
src/torus_route_link_load_core.sv
tb/tb_top.sv
